[rtl/fntd_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Font table directory parser package
// Shared types, result codes, tag constants and the list of known table tags.
// ----------------------------------------------------------------------------
package fntd_pkg;

  localparam int unsigned NUM_TAGS  = 32;
  localparam int unsigned TAG_IDX_W = $clog2(NUM_TAGS);

  // Result kinds.
  localparam logic [1:0] KIND_HEADER = 2'd0;
  localparam logic [1:0] KIND_TABLE  = 2'd1;
  localparam logic [1:0] KIND_ERROR  = 2'd2;

  // Outline flavors.
  localparam logic OUTLINE_CFF = 1'b0;
  localparam logic OUTLINE_TT  = 1'b1;

  // Version tags.
  localparam logic [31:0] VERSION_OTTO = 32'h4F54_544F;
  localparam logic [31:0] VERSION_TT   = 32'h0001_0000;

  // Byte positions that close a field.
  localparam logic [3:0] POS_TAG_END    = 4'd3;
  localparam logic [3:0] POS_HEADER_END = 4'd7;
  localparam logic [3:0] POS_RECORD_END = 4'd15;

  // Parser phase, one-hot.
  typedef enum logic [4:0] {
    PH_IDLE    = 5'b00001,
    PH_VERSION = 5'b00010,
    PH_HEADER  = 5'b00100,
    PH_RECORD  = 5'b01000,
    PH_DONE    = 5'b10000
  } phase_t;

  // One accepted input word.
  typedef struct packed {
    logic [7:0] data_byte;
    logic       file_start;
  } item_t;

  // Outcome of the tag lookup.
  typedef struct packed {
    logic                 hit;
    logic [TAG_IDX_W-1:0] index;
  } tag_match_t;

  localparam logic [31:0] KNOWN_TAGS [NUM_TAGS] = '{
    32'h636D_6170, 32'h6865_6164, 32'h6868_6561, 32'h686D_7478, // cmap head hhea hmtx
    32'h6D61_7870, 32'h6E61_6D65, 32'h4F53_2F32, 32'h706F_7374, // maxp name OS/2 post
    32'h6376_7420, 32'h6670_676D, 32'h676C_7966, 32'h6C6F_6361, // cvt  fpgm glyf loca
    32'h7072_6570, 32'h4346_4620, 32'h564F_5247, 32'h4542_4454, // prep CFF  VORG EBDT
    32'h4542_4C43, 32'h4542_5343, 32'h4241_5345, 32'h4744_4546, // EBLC EBSC BASE GDEF
    32'h4750_4F53, 32'h4753_5542, 32'h4A53_5446, 32'h4453_4947, // GPOS GSUB JSTF DSIG
    32'h6761_7370, 32'h6864_6D78, 32'h6B65_726E, 32'h4C54_5348, // gasp hdmx kern LTSH
    32'h5043_4C54, 32'h5644_4D58, 32'h7668_6561, 32'h766D_7478  // PCLT VDMX vhea vmtx
  };

endpackage

[rtl/fntd_if.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Font table directory parser channels
// Byte stream channel and result channel, valid/ready handshake.
// ----------------------------------------------------------------------------
interface fntd_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       file_start;

  modport source (output valid, data_byte, file_start, input ready);
  modport sink   (input valid, data_byte, file_start, output ready);
endinterface

interface fntd_result_if;
  logic        valid;
  logic        ready;
  logic [1:0]  record_kind;
  logic        outline_type;
  logic [15:0] table_count;
  logic [15:0] search_range;
  logic [15:0] entry_selector;
  logic [15:0] range_shift;
  logic [4:0]  table_index;
  logic [31:0] table_checksum;
  logic [31:0] table_offset;
  logic [31:0] table_length;
  logic        last;

  modport source (output valid, record_kind, outline_type, table_count, search_range,
                  entry_selector, range_shift, table_index, table_checksum,
                  table_offset, table_length, last, input ready);
  modport sink   (input valid, record_kind, outline_type, table_count, search_range,
                  entry_selector, range_shift, table_index, table_checksum,
                  table_offset, table_length, last, output ready);
endinterface

[rtl/fntd_in_reg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Input register
// Holds one accepted byte word until the parse stage takes it.
// ----------------------------------------------------------------------------
module fntd_in_reg (
  input  logic             clk,
  input  logic             rst,
  fntd_byte_if.sink        font,
  input  logic             take,
  output logic             item_valid,
  output fntd_pkg::item_t  item
);

  logic accept;

  assign font.ready = !item_valid || take;
  assign accept     = font.valid && font.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      item_valid <= 1'b0;
    end else if (accept) begin
      item_valid <= 1'b1;
    end else if (take) begin
      item_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      item.data_byte  <= font.data_byte;
      item.file_start <= font.file_start;
    end
  end

endmodule

[rtl/fntd_tag_match.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Table tag matcher
// Compares a four-byte tag with all known tags in parallel.
// ----------------------------------------------------------------------------
module fntd_tag_match (
  input  logic [31:0]           tag,
  output fntd_pkg::tag_match_t  match
);

  logic [fntd_pkg::NUM_TAGS-1:0] hits;

  always_comb begin
    for (int k = 0; k < fntd_pkg::NUM_TAGS; k++) begin
      hits[k] = (tag == fntd_pkg::KNOWN_TAGS[k]);
    end
  end

  // Tags are distinct, so the lowest hit is the only hit.
  always_comb begin
    match.hit   = |hits;
    match.index = '0;
    for (int k = fntd_pkg::NUM_TAGS - 1; k >= 0; k--) begin
      if (hits[k]) begin
        match.index = fntd_pkg::TAG_IDX_W'(k);
      end
    end
  end

endmodule

[rtl/fntd_core.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Parse core
// Tracks the parse phase, assembles words and loads the result register.
// ----------------------------------------------------------------------------
module fntd_core (
  input  logic             clk,
  input  logic             rst,
  input  logic             item_valid,
  input  fntd_pkg::item_t  item,
  output logic             take,
  fntd_result_if.source    result
);

  fntd_pkg::phase_t     phase, phase_next, ph;
  logic [3:0]           pos, pos_next, pos_cur;
  logic [15:0]          records_left, records_left_next, rl_cur, rl_dec;
  logic                 outline_kind, outline_kind_next, ok_cur;
  logic [4:0]           matched_index, matched_index_next;
  logic [31:0]          word0, word1, word2;
  logic [31:0]          word0_next, word1_next, word2_next;
  logic [31:0]          tag_word;
  fntd_pkg::tag_match_t match;

  logic        emit;
  logic [1:0]  res_kind;
  logic        res_outline;
  logic [15:0] res_count, res_range, res_sel, res_shift;
  logic [4:0]  res_index;
  logic [31:0] res_checksum, res_offset, res_length;
  logic        res_last;

  assign take     = item_valid && (!result.valid || result.ready);
  assign tag_word = {word0[23:0], item.data_byte};
  assign rl_dec   = rl_cur - 16'd1;

  fntd_tag_match u_tag_match (
    .tag   (tag_word),
    .match (match)
  );

  always_comb begin
    ph      = item.file_start ? fntd_pkg::PH_VERSION : phase;
    pos_cur = item.file_start ? 4'd0 : pos;
    rl_cur  = item.file_start ? 16'd0 : records_left;
    ok_cur  = item.file_start ? fntd_pkg::OUTLINE_CFF : outline_kind;

    phase_next         = ph;
    pos_next           = pos_cur;
    records_left_next  = rl_cur;
    outline_kind_next  = ok_cur;
    matched_index_next = item.file_start ? 5'd0 : matched_index;
    word0_next         = word0;
    word1_next         = word1;
    word2_next         = word2;

    emit         = 1'b0;
    res_kind     = fntd_pkg::KIND_ERROR;
    res_outline  = fntd_pkg::OUTLINE_CFF;
    res_count    = '0;
    res_range    = '0;
    res_sel      = '0;
    res_shift    = '0;
    res_index    = '0;
    res_checksum = '0;
    res_offset   = '0;
    res_length   = '0;
    res_last     = 1'b0;

    case (ph)
      fntd_pkg::PH_VERSION: begin
        word0_next = tag_word;
        pos_next   = pos_cur + 4'd1;
        if (pos_cur == fntd_pkg::POS_TAG_END) begin
          pos_next = 4'd0;
          if (tag_word == fntd_pkg::VERSION_OTTO) begin
            outline_kind_next = fntd_pkg::OUTLINE_CFF;
            phase_next        = fntd_pkg::PH_HEADER;
          end else if (tag_word == fntd_pkg::VERSION_TT) begin
            outline_kind_next = fntd_pkg::OUTLINE_TT;
            phase_next        = fntd_pkg::PH_HEADER;
          end else begin
            emit       = 1'b1;
            res_kind   = fntd_pkg::KIND_ERROR;
            res_last   = 1'b1;
            phase_next = fntd_pkg::PH_DONE;
          end
        end
      end

      fntd_pkg::PH_HEADER: begin
        if (pos_cur[2]) begin
          word1_next = {word1[23:0], item.data_byte};
        end else begin
          word0_next = tag_word;
        end
        pos_next = pos_cur + 4'd1;
        if (pos_cur == fntd_pkg::POS_HEADER_END) begin
          pos_next          = 4'd0;
          records_left_next = word0[31:16];
          emit              = 1'b1;
          res_kind          = fntd_pkg::KIND_HEADER;
          res_outline       = ok_cur;
          res_count         = word0[31:16];
          res_range         = word0_next[15:0];
          res_sel           = word1_next[31:16];
          res_shift         = word1_next[15:0];
          res_last          = (word0[31:16] == 16'd0);
          phase_next        = res_last ? fntd_pkg::PH_DONE : fntd_pkg::PH_RECORD;
        end
      end

      fntd_pkg::PH_RECORD: begin
        pos_next = pos_cur + 4'd1;
        case (pos_cur[3:2])
          2'd0, 2'd1: word0_next = tag_word;
          2'd2:       word1_next = {word1[23:0], item.data_byte};
          default:    word2_next = {word2[23:0], item.data_byte};
        endcase
        if (pos_cur == fntd_pkg::POS_TAG_END) begin
          if (match.hit) begin
            matched_index_next = match.index;
          end else begin
            emit        = 1'b1;
            res_kind    = fntd_pkg::KIND_ERROR;
            res_outline = ok_cur;
            res_last    = 1'b1;
            pos_next    = 4'd0;
            phase_next  = fntd_pkg::PH_DONE;
          end
        end
        if (pos_cur == fntd_pkg::POS_RECORD_END) begin
          pos_next          = 4'd0;
          records_left_next = rl_dec;
          emit              = 1'b1;
          res_kind          = fntd_pkg::KIND_TABLE;
          res_outline       = ok_cur;
          res_index         = matched_index;
          res_checksum      = word0;
          res_offset        = word1;
          res_length        = word2_next;
          res_last          = (rl_dec == 16'd0);
          if (res_last) begin
            phase_next = fntd_pkg::PH_DONE;
          end
        end
      end

      default: begin
        // Idle or stopped: the byte is dropped.
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase         <= fntd_pkg::PH_IDLE;
      pos           <= 4'd0;
      records_left  <= 16'd0;
      outline_kind  <= fntd_pkg::OUTLINE_CFF;
      matched_index <= 5'd0;
      result.valid  <= 1'b0;
    end else begin
      if (take) begin
        phase         <= phase_next;
        pos           <= pos_next;
        records_left  <= records_left_next;
        outline_kind  <= outline_kind_next;
        matched_index <= matched_index_next;
      end
      if (take && emit) begin
        result.valid <= 1'b1;
      end else if (result.ready) begin
        result.valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      word0 <= word0_next;
      word1 <= word1_next;
      word2 <= word2_next;
    end
    if (take && emit) begin
      result.record_kind    <= res_kind;
      result.outline_type   <= res_outline;
      result.table_count    <= res_count;
      result.search_range   <= res_range;
      result.entry_selector <= res_sel;
      result.range_shift    <= res_shift;
      result.table_index    <= res_index;
      result.table_checksum <= res_checksum;
      result.table_offset   <= res_offset;
      result.table_length   <= res_length;
      result.last           <= res_last;
    end
  end

endmodule

[rtl/font_table_directory_parser.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Font table directory parser
// Walks the version tag, header and table directory of a font file given one
// byte per word, and reports the header and each known table record.
// ----------------------------------------------------------------------------
//
//   Channel   Direction  Word contents
//   font      in         data_byte, file_start (first byte of a new file)
//   result    out        record_kind, outline_type, header words, table index,
//                        checksum, offset, length, last
//
// The parse stage closes each byte word as it takes it, so one word per cycle is
// sustained while the result is not stalled; an accepted byte is held in the input
// register for the parse stage, and a result it causes is held in the result
// register. The throughput is set by the single parse stage, one byte per clock.
// Reset (synchronous, active high) empties both registers and leaves the parser
// idle until a byte marked as a file start arrives.
// A stalled result holds the parse stage; a byte already in the input register
// waits there, an empty input register still takes one byte, and further bytes
// wait on font.ready.
//
// A file start restarts the parse from any phase. The first four bytes must be
// 'OTTO' (CFF) or 00 01 00 00 (TrueType); anything else gives an error result
// and the parser stops. Eight header bytes give the header result. Each 16-byte
// directory record is matched on its tag; an unknown tag gives an error result
// after its fourth byte and the parser stops. The last result for a file has
// last set, after which bytes are ignored until the next file start.
// ----------------------------------------------------------------------------
module font_table_directory_parser (
  input  logic          clk,
  input  logic          rst,
  fntd_byte_if.sink     font,
  fntd_result_if.source result
);

  logic            item_valid;
  logic            take;
  fntd_pkg::item_t item;

  // Input register: decouples the byte source from a stalled result.
  fntd_in_reg u_in_reg (
    .clk        (clk),
    .rst        (rst),
    .font       (font),
    .take       (take),
    .item_valid (item_valid),
    .item       (item)
  );

  // Parse stage: phase tracking, word assembly, tag lookup, result register.
  fntd_core u_core (
    .clk        (clk),
    .rst        (rst),
    .item_valid (item_valid),
    .item       (item),
    .take       (take),
    .result     (result)
  );

endmodule
